@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_IMPLY(label, clk, rst, cond, expr)

`endif

`endif

@@ rtl/gzr2_pkg.sv @@
// ---------------------------------------------------------------------------
// gzr2_pkg
// Shared widths, register indexes and micro-op decode of the radix-2
// Goertzel bin core.
// ---------------------------------------------------------------------------
`default_nettype none

package gzr2_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_WIDTH      = 16;
  localparam int ACC_WIDTH       = 48;
  localparam int RESULT_WIDTH    = 48;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int OUT_TDATA_WIDTH = 2 * RESULT_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LANE_COS    = 2'd0,
    REG_LANE_SIN    = 2'd1,
    REG_TWIDDLE_COS = 2'd2,
    REG_TWIDDLE_SIN = 2'd3
  } cfg_reg_t;

  // Micro-ops, in program order.
  typedef enum logic [3:0] {
    OP_UPD_MUL  = 4'd0,
    OP_UPD_ADD  = 4'd1,
    OP_FIN_A_RE = 4'd2,
    OP_FIN_A_IM = 4'd3,
    OP_FIN_B_RE = 4'd4,
    OP_FIN_B_IM = 4'd5,
    OP_ROT_1    = 4'd6,
    OP_ROT_2    = 4'd7,
    OP_ROT_3    = 4'd8,
    OP_ROT_4    = 4'd9,
    OP_ROT_5    = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    LANE_ITEM = 2'd0,
    LANE_EVEN = 2'd1,
    LANE_ODD  = 2'd2
  } lane_mode_t;

  typedef enum logic [1:0] {
    MSRC_S1 = 2'd0,
    MSRC_RE = 2'd1,
    MSRC_IM = 2'd2
  } msrc_t;

  typedef enum logic [1:0] {
    COEF_LANE_COS = 2'd0,
    COEF_LANE_SIN = 2'd1,
    COEF_TW_COS   = 2'd2,
    COEF_TW_SIN   = 2'd3
  } coef_sel_t;

  typedef enum logic [1:0] {
    ASRC_RND = 2'd0,
    ASRC_T0  = 2'd1,
    ASRC_T1  = 2'd2
  } asrc_t;

  typedef enum logic [1:0] {
    BSRC_S2   = 2'd0,
    BSRC_X    = 2'd1,
    BSRC_RND  = 2'd2,
    BSRC_ZERO = 2'd3
  } bsrc_t;

  typedef enum logic [2:0] {
    DST_T0   = 3'd0,
    DST_T1   = 3'd1,
    DST_LANE = 3'd2,
    DST_RE   = 3'd3,
    DST_IM   = 3'd4
  } dest_t;

  typedef struct packed {
    lane_mode_t lane_mode;
    msrc_t      mul_src;
    coef_sel_t  coef_sel;
    logic       double_coef;  // recurrence coefficient: one less fraction bit
    asrc_t      a_src;
    bsrc_t      b_src;
    logic       sub;
    dest_t      dest;
    logic       has_mul;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic lane_b;
    logic load_x;
    logic mul_en;
    logic rnd_en;
    logic alu_en;
    logic sum_load;
  } dp_cmd_t;

  function automatic uop_t decode_op(op_t op);
    uop_t u;
    u = '{LANE_ITEM, MSRC_S1, COEF_LANE_COS, 1'b0, ASRC_RND, BSRC_ZERO, 1'b0, DST_T0, 1'b0};
    unique case (op)
      OP_UPD_MUL:  u = '{LANE_ITEM, MSRC_S1, COEF_LANE_COS, 1'b1, ASRC_RND, BSRC_S2,
                         1'b1, DST_T0, 1'b1};
      OP_UPD_ADD:  u = '{LANE_ITEM, MSRC_S1, COEF_LANE_COS, 1'b0, ASRC_T0, BSRC_X,
                         1'b0, DST_LANE, 1'b0};
      OP_FIN_A_RE: u = '{LANE_EVEN, MSRC_S1, COEF_LANE_COS, 1'b0, ASRC_RND, BSRC_S2,
                         1'b1, DST_RE, 1'b1};
      OP_FIN_A_IM: u = '{LANE_EVEN, MSRC_S1, COEF_LANE_SIN, 1'b0, ASRC_RND, BSRC_ZERO,
                         1'b0, DST_IM, 1'b1};
      OP_FIN_B_RE: u = '{LANE_ODD, MSRC_S1, COEF_LANE_COS, 1'b0, ASRC_RND, BSRC_S2,
                         1'b1, DST_RE, 1'b1};
      OP_FIN_B_IM: u = '{LANE_ODD, MSRC_S1, COEF_LANE_SIN, 1'b0, ASRC_RND, BSRC_ZERO,
                         1'b0, DST_IM, 1'b1};
      OP_ROT_1:    u = '{LANE_ITEM, MSRC_RE, COEF_TW_COS, 1'b0, ASRC_RND, BSRC_ZERO,
                         1'b0, DST_T0, 1'b1};
      OP_ROT_2:    u = '{LANE_ITEM, MSRC_IM, COEF_TW_SIN, 1'b0, ASRC_T0, BSRC_RND,
                         1'b1, DST_T1, 1'b1};
      OP_ROT_3:    u = '{LANE_ITEM, MSRC_RE, COEF_TW_SIN, 1'b0, ASRC_RND, BSRC_ZERO,
                         1'b0, DST_T0, 1'b1};
      OP_ROT_4:    u = '{LANE_ITEM, MSRC_IM, COEF_TW_COS, 1'b0, ASRC_T0, BSRC_RND,
                         1'b0, DST_IM, 1'b1};
      OP_ROT_5:    u = '{LANE_ITEM, MSRC_RE, COEF_TW_COS, 1'b0, ASRC_T1, BSRC_ZERO,
                         1'b0, DST_RE, 1'b0};
      default:     u = '{LANE_ITEM, MSRC_S1, COEF_LANE_COS, 1'b0, ASRC_RND, BSRC_ZERO,
                         1'b0, DST_T0, 1'b0};
    endcase
    return u;
  endfunction

  function automatic op_t next_op(op_t op);
    op_t n;
    n = OP_UPD_MUL;
    unique case (op)
      OP_UPD_MUL:  n = OP_UPD_ADD;
      OP_UPD_ADD:  n = OP_FIN_A_RE;
      OP_FIN_A_RE: n = OP_FIN_A_IM;
      OP_FIN_A_IM: n = OP_FIN_B_RE;
      OP_FIN_B_RE: n = OP_FIN_B_IM;
      OP_FIN_B_IM: n = OP_ROT_1;
      OP_ROT_1:    n = OP_ROT_2;
      OP_ROT_2:    n = OP_ROT_3;
      OP_ROT_3:    n = OP_ROT_4;
      OP_ROT_4:    n = OP_ROT_5;
      OP_ROT_5:    n = OP_UPD_MUL;
      default:     n = OP_UPD_MUL;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/goertzel_radix2_bin_core.sv @@
// An inner sample runs through multiply, round and two add steps.
// A last sample runs the lane finish and rotation through the one shared
// multiplier; its block result is loaded once the output register is free.
// No new sample is taken until the last one is through; one result per block.
// Reset (rst, synchronous, active high) clears lane state and the sample
// index and loads cos terms with 1.0 and sin terms with 0.
// ---------------------------------------------------------------------------
// goertzel_radix2_bin_core
// Radix-2 Goertzel single-bin detector: even/odd lanes, rotation, combine.
// ---------------------------------------------------------------------------
`default_nettype none

module goertzel_radix2_bin_core #(
  parameter int SAMPLE_WIDTH = gzr2_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = gzr2_pkg::COEF_WIDTH,
  parameter int ACC_WIDTH    = gzr2_pkg::ACC_WIDTH,
  localparam int IN_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [IN_TDATA_WIDTH-1:0]            s_axis_tdata,  // sample
  input  wire logic                                 s_axis_tlast,  // last_sample
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [gzr2_pkg::OUT_TDATA_WIDTH-1:0]      m_axis_tdata,  // real_part, imag_part
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [gzr2_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]                cfg_data
);

  gzr2_pkg::dp_cmd_t                  cmd;
  logic [gzr2_pkg::RESULT_WIDTH-1:0]  real_part;
  logic [gzr2_pkg::RESULT_WIDTH-1:0]  imag_part;

  // take register writes only while no sample is being processed
  assign cfg_ready    = s_axis_tready;
  assign m_axis_tdata = {imag_part, real_part};

  gzr2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  gzr2_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .cmd       (cmd),
    .real_part (real_part),
    .imag_part (imag_part)
  );

endmodule

`default_nettype wire

@@ rtl/gzr2_dpath.sv @@
// ---------------------------------------------------------------------------
// gzr2_dpath
// Lane state, coefficient registers, shared multiplier with rounding and
// saturation, saturating add/sub unit and the final lane combine.
// ---------------------------------------------------------------------------
`default_nettype none

module gzr2_dpath #(
  parameter int SAMPLE_WIDTH = gzr2_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = gzr2_pkg::COEF_WIDTH,
  parameter int ACC_WIDTH    = gzr2_pkg::ACC_WIDTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic [gzr2_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]                cfg_data,
  input  wire logic [SAMPLE_WIDTH-1:0]              sample,
  input  wire gzr2_pkg::dp_cmd_t                    cmd,
  output logic [gzr2_pkg::RESULT_WIDTH-1:0]         real_part,
  output logic [gzr2_pkg::RESULT_WIDTH-1:0]         imag_part
);

  localparam int PW   = ACC_WIDTH + COEF_WIDTH;
  localparam int FRAC = COEF_WIDTH - 2;
  localparam int RW   = gzr2_pkg::RESULT_WIDTH;
  localparam int SW   = ((ACC_WIDTH > RW) ? ACC_WIDTH : RW) + 1;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = {2'b01, {(COEF_WIDTH-2){1'b0}}};
  localparam logic signed [PW:0] RND_MAX =
    {{(PW - ACC_WIDTH + 2){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [PW:0] RND_MIN = ~RND_MAX;
  localparam logic signed [PW:0] BIAS_FULL = (PW+1)'(1) << (FRAC - 1);
  localparam logic signed [PW:0] BIAS_HALF = (PW+1)'(1) << (FRAC - 2);
  localparam logic signed [ACC_WIDTH:0] ALU_MAX = {2'b00, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH:0] ALU_MIN = ~ALU_MAX;
  localparam logic signed [SW-1:0] RES_MAX = {{(SW - RW + 1){1'b0}}, {(RW-1){1'b1}}};
  localparam logic signed [SW-1:0] RES_MIN = ~RES_MAX;

  logic signed [COEF_WIDTH-1:0] lane_cos, lane_sin, twiddle_cos, twiddle_sin;
  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [ACC_WIDTH-1:0] s1_a, s2_a, s1_b, s2_b;
  logic signed [ACC_WIDTH-1:0] re_a, im_a, re_b, im_b;
  logic signed [ACC_WIDTH-1:0] t0, t1, rnd;
  logic signed [PW-1:0] prod;

  logic signed [ACC_WIDTH-1:0] s1_sel, s2_sel, re_sel, im_sel, mul_a, x_ext;
  logic signed [COEF_WIDTH-1:0] coef;
  logic signed [PW-1:0] mul_a_ext, coef_ext;
  logic signed [PW:0] rnd_ext, rnd_bias, rnd_sum, rnd_shift;
  logic signed [ACC_WIDTH-1:0] rnd_next;
  logic signed [ACC_WIDTH-1:0] alu_a, alu_b, alu_y;
  logic signed [ACC_WIDTH:0] alu_sum;
  logic signed [SW-1:0] sum_re, sum_im;
  logic signed [RW-1:0] sum_re_sat, sum_im_sat;

  always_comb begin
    s1_sel = cmd.lane_b ? s1_b : s1_a;
    s2_sel = cmd.lane_b ? s2_b : s2_a;
    re_sel = cmd.lane_b ? re_b : re_a;
    im_sel = cmd.lane_b ? im_b : im_a;
    x_ext  = {{(ACC_WIDTH - SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};
  end

  // Multiplier operands
  always_comb begin
    unique case (cmd.uop.mul_src)
      gzr2_pkg::MSRC_S1: mul_a = s1_sel;
      gzr2_pkg::MSRC_RE: mul_a = re_sel;
      gzr2_pkg::MSRC_IM: mul_a = im_sel;
      default:           mul_a = s1_sel;
    endcase
    unique case (cmd.uop.coef_sel)
      gzr2_pkg::COEF_LANE_COS: coef = lane_cos;
      gzr2_pkg::COEF_LANE_SIN: coef = lane_sin;
      gzr2_pkg::COEF_TW_COS:   coef = twiddle_cos;
      gzr2_pkg::COEF_TW_SIN:   coef = twiddle_sin;
    endcase
    mul_a_ext = {{COEF_WIDTH{mul_a[ACC_WIDTH-1]}}, mul_a};
    coef_ext  = {{ACC_WIDTH{coef[COEF_WIDTH-1]}}, coef};
  end

  // Round half away from zero: add half (less one when negative), then shift.
  always_comb begin
    rnd_ext  = {prod[PW-1], prod};
    rnd_bias = (cmd.uop.double_coef ? BIAS_HALF : BIAS_FULL)
               - {{PW{1'b0}}, prod[PW-1]};
    rnd_sum  = rnd_ext + rnd_bias;
    rnd_shift = cmd.uop.double_coef ? (rnd_sum >>> (FRAC - 1)) : (rnd_sum >>> FRAC);
    if (rnd_shift > RND_MAX) begin
      rnd_next = RND_MAX[ACC_WIDTH-1:0];
    end else if (rnd_shift < RND_MIN) begin
      rnd_next = RND_MIN[ACC_WIDTH-1:0];
    end else begin
      rnd_next = rnd_shift[ACC_WIDTH-1:0];
    end
  end

  // Saturating add/sub
  always_comb begin
    unique case (cmd.uop.a_src)
      gzr2_pkg::ASRC_RND: alu_a = rnd;
      gzr2_pkg::ASRC_T0:  alu_a = t0;
      gzr2_pkg::ASRC_T1:  alu_a = t1;
      default:            alu_a = rnd;
    endcase
    unique case (cmd.uop.b_src)
      gzr2_pkg::BSRC_S2:   alu_b = s2_sel;
      gzr2_pkg::BSRC_X:    alu_b = x_ext;
      gzr2_pkg::BSRC_RND:  alu_b = rnd;
      gzr2_pkg::BSRC_ZERO: alu_b = '0;
    endcase
    if (cmd.uop.sub) begin
      alu_sum = {alu_a[ACC_WIDTH-1], alu_a} - {alu_b[ACC_WIDTH-1], alu_b};
    end else begin
      alu_sum = {alu_a[ACC_WIDTH-1], alu_a} + {alu_b[ACC_WIDTH-1], alu_b};
    end
    if (alu_sum > ALU_MAX) begin
      alu_y = ALU_MAX[ACC_WIDTH-1:0];
    end else if (alu_sum < ALU_MIN) begin
      alu_y = ALU_MIN[ACC_WIDTH-1:0];
    end else begin
      alu_y = alu_sum[ACC_WIDTH-1:0];
    end
  end

  // Lane combine, saturated to the result width
  always_comb begin
    sum_re = {{(SW - ACC_WIDTH){re_a[ACC_WIDTH-1]}}, re_a}
           + {{(SW - ACC_WIDTH){re_b[ACC_WIDTH-1]}}, re_b};
    sum_im = {{(SW - ACC_WIDTH){im_a[ACC_WIDTH-1]}}, im_a}
           + {{(SW - ACC_WIDTH){im_b[ACC_WIDTH-1]}}, im_b};
    if (sum_re > RES_MAX) begin
      sum_re_sat = RES_MAX[RW-1:0];
    end else if (sum_re < RES_MIN) begin
      sum_re_sat = RES_MIN[RW-1:0];
    end else begin
      sum_re_sat = sum_re[RW-1:0];
    end
    if (sum_im > RES_MAX) begin
      sum_im_sat = RES_MAX[RW-1:0];
    end else if (sum_im < RES_MIN) begin
      sum_im_sat = RES_MIN[RW-1:0];
    end else begin
      sum_im_sat = sum_im[RW-1:0];
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cos    <= COEF_ONE;
      lane_sin    <= '0;
      twiddle_cos <= COEF_ONE;
      twiddle_sin <= '0;
    end else if (cfg_valid) begin
      unique case (gzr2_pkg::cfg_reg_t'(cfg_index))
        gzr2_pkg::REG_LANE_COS:    lane_cos    <= cfg_data;
        gzr2_pkg::REG_LANE_SIN:    lane_sin    <= cfg_data;
        gzr2_pkg::REG_TWIDDLE_COS: twiddle_cos <= cfg_data;
        gzr2_pkg::REG_TWIDDLE_SIN: twiddle_sin <= cfg_data;
      endcase
    end
  end

  // Lane recurrence state
  always_ff @(posedge clk) begin
    if (rst || cmd.sum_load) begin
      s1_a <= '0;
      s2_a <= '0;
      s1_b <= '0;
      s2_b <= '0;
    end else if (cmd.alu_en && cmd.uop.dest == gzr2_pkg::DST_LANE) begin
      if (cmd.lane_b) begin
        s2_b <= s1_b;
        s1_b <= alu_y;
      end else begin
        s2_a <= s1_a;
        s1_a <= alu_y;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_reg <= sample;
    end
    if (cmd.mul_en) begin
      prod <= mul_a_ext * coef_ext;
    end
    if (cmd.rnd_en) begin
      rnd <= rnd_next;
    end
    if (cmd.alu_en) begin
      unique case (cmd.uop.dest)
        gzr2_pkg::DST_T0:   t0 <= alu_y;
        gzr2_pkg::DST_T1:   t1 <= alu_y;
        gzr2_pkg::DST_LANE: ;
        gzr2_pkg::DST_RE: begin
          if (cmd.lane_b) re_b <= alu_y;
          else            re_a <= alu_y;
        end
        gzr2_pkg::DST_IM: begin
          if (cmd.lane_b) im_b <= alu_y;
          else            im_a <= alu_y;
        end
        default: ;
      endcase
    end
    if (cmd.sum_load) begin
      real_part <= sum_re_sat;
      imag_part <= sum_im_sat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gzr2_ctrl.sv @@
// ---------------------------------------------------------------------------
// gzr2_ctrl
// Sequencer: steps each sample and the end-of-block combine through the
// micro-op program and owns the stream handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gzr2_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output gzr2_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_RND  = 5'b00100,
    S_ALU  = 5'b01000,
    S_SUM  = 5'b10000
  } state_t;

  state_t             state;
  gzr2_pkg::op_t      pc;
  gzr2_pkg::op_t      pc_next;
  gzr2_pkg::uop_t     uop;
  gzr2_pkg::uop_t     uop_next;
  logic               lane_item;
  logic               last_item;
  logic               odd_index;
  logic               lane_b;
  logic               sum_fire;

  always_comb begin
    uop      = gzr2_pkg::decode_op(pc);
    pc_next  = gzr2_pkg::next_op(pc);
    uop_next = gzr2_pkg::decode_op(pc_next);
    unique case (uop.lane_mode)
      gzr2_pkg::LANE_ITEM: lane_b = lane_item;
      gzr2_pkg::LANE_EVEN: lane_b = 1'b0;
      gzr2_pkg::LANE_ODD:  lane_b = 1'b1;
      default:             lane_b = lane_item;
    endcase
    // the output register must be free before the combine lands in it
    sum_fire = (state == S_SUM) && (!out_valid || out_ready);
    in_ready = (state == S_IDLE);

    cmd.uop      = uop;
    cmd.lane_b   = lane_b;
    cmd.load_x   = in_valid && (state == S_IDLE);
    cmd.mul_en   = (state == S_MUL);
    cmd.rnd_en   = (state == S_RND);
    cmd.alu_en   = (state == S_ALU);
    cmd.sum_load = sum_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= gzr2_pkg::OP_UPD_MUL;
      lane_item <= 1'b0;
      last_item <= 1'b0;
      odd_index <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sum_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            lane_item <= odd_index;
            last_item <= in_last;
            pc        <= gzr2_pkg::OP_UPD_MUL;
            state     <= S_MUL;
          end
        end
        S_MUL: state <= S_RND;
        S_RND: state <= S_ALU;
        S_ALU: begin
          if (pc == gzr2_pkg::OP_UPD_ADD) begin
            odd_index <= ~odd_index;
            if (last_item) begin
              pc    <= pc_next;
              state <= S_MUL;
            end else begin
              state <= S_IDLE;
            end
          end else if (pc == gzr2_pkg::OP_ROT_5) begin
            state <= S_SUM;
          end else begin
            pc    <= pc_next;
            state <= uop_next.has_mul ? S_MUL : S_ALU;
          end
        end
        S_SUM: begin
          if (sum_fire) begin
            odd_index <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_PROP(a_accept_starts_update, clk, rst,
               (in_valid && in_ready) |=> (state == S_MUL && pc == gzr2_pkg::OP_UPD_MUL))
  `ASSERT_IMPLY(a_combine_only_on_last, clk, rst, state == S_SUM, last_item)
  `ASSERT_PROP(a_result_from_combine, clk, rst, $rose(out_valid) |-> $past(state == S_SUM))
  `ASSERT_PROP(a_index_cleared_after_block, clk, rst, sum_fire |=> !odd_index)
  `ASSERT_PROP(a_mid_block_alternates, clk, rst,
               (state == S_ALU && pc == gzr2_pkg::OP_UPD_ADD && !last_item) |=>
               (state == S_IDLE && odd_index != $past(odd_index)))

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the radix-2 Goertzel bin core. Streams blocks of
// samples under random gaps and output stalls, recomputes every bin from a
// fixed-point model of both lanes, the lane finish and the twiddle rotation,
// and compares each result transaction field by field. Coefficients are
// rewritten between phases while the core is idle.
// ---------------------------------------------------------------------------
module testbench;
  import gzr2_pkg::*;

  localparam int FRAC       = COEF_WIDTH - 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 40;
  localparam int PHASE_LEN  = 150;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [SAMPLE_WIDTH-1:0] sample;
    bit                      last;
    int                      gap;
    bit                      hold;   // wait for every pending bin before sending
  } sample_item_t;

  typedef struct {
    longint re;
    longint im;
  } bin_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [SAMPLE_WIDTH-1:0]      s_axis_tdata = '0;   // sample
  logic                         s_axis_tlast = 1'b0; // last_sample
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0]   m_axis_tdata;        // real_part, imag_part
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
  logic [COEF_WIDTH-1:0]        cfg_data = '0;

  goertzel_radix2_bin_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // Shadow of the coefficient registers and of the lane state.
  logic [COEF_WIDTH-1:0] coef_reg [4];
  longint                even_s1, even_s2, odd_s1, odd_s2;
  bit                    odd_next;

  sample_item_t sample_queue [$];
  bin_t         expected_bins [$];
  sample_item_t in_flight;
  int           gap_left = -1;
  int           stall_left = 0;
  bit           quiet = 1'b0;
  int           bins_expected = 0;
  int           bins_seen = 0;
  int           samples_taken = 0;
  int           reg_writes = 0;
  int           errors = 0;
  int           idle_cycles = 0;

  function automatic longint saturate(wide_t v, int w);
    wide_t top;
    wide_t bottom;
    top = (wide_t'(1) << (w - 1)) - 1;
    bottom = -top - 1;
    if (v > top) return longint'(top);
    if (v < bottom) return longint'(bottom);
    return longint'(v);
  endfunction

  // round(a*c / 2^sh) half away from zero, saturated to the accumulator width
  function automatic longint scaled_product(longint a, longint c, int sh);
    wide_t        p;
    logic [127:0] mag;
    logic [127:0] lim;
    bit           neg;
    p = wide_t'(a) * wide_t'(c);
    neg = (a < 0) != (c < 0);
    mag = (p < 0) ? -p : p;
    mag = (mag + (128'd1 << (sh - 1))) >> sh;
    lim = (128'd1 << (ACC_WIDTH - 1)) - (neg ? 128'd0 : 128'd1);
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint coef(cfg_reg_t idx);
    return longint'($signed(coef_reg[idx]));
  endfunction

  function automatic longint lane_next(longint s1, longint s2, longint x);
    longint t;
    t = saturate(scaled_product(s1, coef(REG_LANE_COS), FRAC - 1) - s2, ACC_WIDTH);
    return saturate(t + x, ACC_WIDTH);
  endfunction

  function automatic bin_t lane_bin(longint s1, longint s2, bit rotate);
    bin_t   b;
    longint tc;
    longint ts;
    b.re = saturate(scaled_product(s1, coef(REG_LANE_COS), FRAC) - s2, ACC_WIDTH);
    b.im = scaled_product(s1, coef(REG_LANE_SIN), FRAC);
    if (rotate) begin
      tc = coef(REG_TWIDDLE_COS);
      ts = coef(REG_TWIDDLE_SIN);
      return '{saturate(scaled_product(b.re, tc, FRAC) - scaled_product(b.im, ts, FRAC),
                        ACC_WIDTH),
               saturate(scaled_product(b.re, ts, FRAC) + scaled_product(b.im, tc, FRAC),
                        ACC_WIDTH)};
    end
    return b;
  endfunction

  // Advance the lane that owns this sample; on the last one, close the block.
  function automatic void take_sample(logic [SAMPLE_WIDTH-1:0] raw, bit last);
    longint x;
    longint t;
    bit     was_odd;
    bin_t   a;
    bin_t   b;
    x = longint'($signed(raw));
    was_odd = odd_next;
    if (was_odd) begin
      t = lane_next(odd_s1, odd_s2, x);
      odd_s2 = odd_s1;
      odd_s1 = t;
    end else begin
      t = lane_next(even_s1, even_s2, x);
      even_s2 = even_s1;
      even_s1 = t;
    end
    odd_next = !was_odd;
    if (last) begin
      // even block length: the odd lane is rotated, else the even lane
      a = lane_bin(even_s1, even_s2, !was_odd);
      b = lane_bin(odd_s1, odd_s2, was_odd);
      expected_bins.push_back('{saturate(a.re + b.re, RESULT_WIDTH),
                                saturate(a.im + b.im, RESULT_WIDTH)});
      bins_expected++;
      even_s1 = 0;
      even_s2 = 0;
      odd_s1 = 0;
      odd_s2 = 0;
      odd_next = 1'b0;
    end
  endfunction

  // Sample driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = -1;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_sample(in_flight.sample, in_flight.last);
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_queue.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          if (gap_left < 0) gap_left = sample_queue[0].gap;
          if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
          end else if (sample_queue[0].hold && bins_seen != bins_expected) begin
            s_axis_tvalid <= 1'b0;
          end else begin
            in_flight = sample_queue.pop_front();
            gap_left = -1;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= in_flight.sample;
            s_axis_tlast <= in_flight.last;
          end
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    bin_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bins.size() == 0) begin
          errors++;
          $display("%0t: unexpected bin: expected none, got re=%0d im=%0d", $time,
                   $signed(m_axis_tdata[RESULT_WIDTH-1:0]),
                   $signed(m_axis_tdata[2*RESULT_WIDTH-1:RESULT_WIDTH]));
        end else begin
          want = expected_bins.pop_front();
          if (m_axis_tdata[RESULT_WIDTH-1:0] !== want.re[RESULT_WIDTH-1:0]) begin
            errors++;
            $display("%0t: real_part mismatch: expected %0d, got %0d", $time, want.re,
                     $signed(m_axis_tdata[RESULT_WIDTH-1:0]));
          end
          if (m_axis_tdata[2*RESULT_WIDTH-1:RESULT_WIDTH] !== want.im[RESULT_WIDTH-1:0]) begin
            errors++;
            $display("%0t: imag_part mismatch: expected %0d, got %0d", $time, want.im,
                     $signed(m_axis_tdata[2*RESULT_WIDTH-1:RESULT_WIDTH]));
          end
        end
        bins_seen <= bins_seen + 1;
        stall_left = quiet ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Abort when no transaction of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_sample(logic [SAMPLE_WIDTH-1:0] sample, bit last, bit hold = 1'b0);
    sample_queue.push_back('{sample, last, quiet ? 0 : int'($urandom_range(0, 13)), hold});
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] draw_sample(int style);
    case (style)
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          3: return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      2: return SAMPLE_WIDTH'(int'($urandom_range(0, 200)) - 100);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Wait until the core has drained, plus its worst-case latency.
  task automatic settle();
    while (sample_queue.size() != 0 || s_axis_tvalid || bins_seen != bins_expected)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [COEF_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    coef_reg[idx] = value;
    reg_writes++;
  endtask

  initial begin
    logic [COEF_WIDTH-1:0] settings [8][4];
    int                    count;
    int                    len;
    int                    style;

    coef_reg[REG_LANE_COS]    = 16'd16384;
    coef_reg[REG_LANE_SIN]    = 16'd0;
    coef_reg[REG_TWIDDLE_COS] = 16'd16384;
    coef_reg[REG_TWIDDLE_SIN] = 16'd0;
    even_s1 = 0;
    even_s2 = 0;
    odd_s1 = 0;
    odd_s2 = 0;
    odd_next = 1'b0;

    settings[0] = '{16'd16384, 16'd0, 16'd16384, 16'd0};
    settings[1] = '{16'd11585, 16'd11585, 16'd15137, -16'sd6270};
    settings[2] = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    settings[3] = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    settings[4] = '{-16'sd16384, 16'd16384, -16'sd16384, 16'd16384};
    settings[5] = '{16'd0, 16'd0, 16'd0, 16'd0};
    settings[6] = '{16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384)};
    settings[7] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed blocks at reset coefficients: single-sample blocks, both
    // length parities, full-scale extremes and an all-zero block.
    push_sample(16'h7FFF, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h7FFF, 1'b0);  push_sample(16'h8000, 1'b1);
    push_sample(16'h8000, 1'b0);  push_sample(16'h7FFF, 1'b0);  push_sample(16'h0001, 1'b1);
    push_sample(16'h5555, 1'b0, 1'b1);  push_sample(16'hAAAA, 1'b0);
    push_sample(16'h7FFF, 1'b0);  push_sample(16'h8000, 1'b1);
    for (int i = 0; i < 5; i++) push_sample(16'h0000, i == 4);
    push_sample(16'hFFFF, 1'b0);  push_sample(16'h0001, 1'b1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      quiet = (ph % 3 == 2);
      if (ph != 0) begin
        for (int r = 0; r < 4; r++) write_register(cfg_reg_t'(r), settings[ph][r]);
        cfg_valid <= 1'b0;
      end
      count = 0;
      while (count < PHASE_LEN) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
          push_sample(draw_sample(style), i == len - 1, i == 0 && $urandom_range(0, 7) == 0);
        count += len;
      end
      // leave a block open across the coefficient change
      if ($urandom_range(0, 1)) begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_sample(draw_sample(0), 1'b0);
      end
      settle();
    end

    if (expected_bins.size() != 0) begin
      errors += expected_bins.size();
      $display("%0t: %0d bins expected but never produced", $time, expected_bins.size());
    end
    $display("summary: %0d samples, %0d bins checked, %0d register writes",
             samples_taken, bins_seen, reg_writes);
    $display("summary: 8 coefficient settings incl. full-scale, zero and identity");
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
